/* src/pcx_pkg.sv */
// shared types and constants of the pcx run-length row decoder
package pcx_pkg;

    localparam int BYTE_W    = 8;
    localparam int ROW_LEN_W = 15;
    localparam int COUNT_W   = 6;

    localparam logic [BYTE_W-1:0]    CODE_MASK     = 8'hC0;
    localparam logic [BYTE_W-1:0]    COUNT_MASK    = 8'h3F;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 15'd320;

    typedef enum logic [1:0] {
        S_CODE,
        S_VALUE,
        S_RUN,
        S_HALT
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_lit;
        logic load_count;
        logic start_run;
        logic emit;
        logic load_err;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_code;
        logic out_free;
        logic run_empty;
        logic run_err;
        logic run_last_px;
    } stat_t;

endpackage

/* src/pcx_ctrl.sv */
// controller state machine of the pcx run-length row decoder
module pcx_ctrl
    import pcx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stat_t  stat,
    output cmd_t   cmd,
    output state_t state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CODE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CODE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (stat.is_code)
                    begin
                        cmd.load_count = 1'b1;
                        state_next     = S_VALUE;
                    end
                    else
                    begin
                        cmd.load_lit = 1'b1;
                    end
                end
            end
            S_VALUE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (stat.run_empty)
                    begin
                        state_next = S_CODE;
                    end
                    else if (stat.run_err)
                    begin
                        cmd.load_err = 1'b1;
                        state_next   = S_HALT;
                    end
                    else
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.run_last_px)
                    begin
                        state_next = S_CODE;
                    end
                end
            end
            S_HALT:
            begin
                // every later item is dropped
                in_ready = 1'b1;
            end
            default:
            begin
                state_next = S_CODE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

/* src/pcx_dpath.sv */
// datapath of the pcx run-length row decoder: row position, run counter, output register
module pcx_dpath
    import pcx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_W-1:0]    code_byte,
    input  logic                 cfg_valid,
    input  logic [ROW_LEN_W-1:0] row_length,
    input  logic                 out_ready,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 out_valid,
    output logic [BYTE_W-1:0]    pixel,
    output logic                 run_last,
    output logic                 row_end,
    output logic                 overrun_error
);

    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [ROW_LEN_W-1:0] column_reg;
    logic [ROW_LEN_W-1:0] column_next;
    logic [COUNT_W-1:0]   run_count_reg;
    logic [COUNT_W-1:0]   left_reg;
    logic [BYTE_W-1:0]    value_reg;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    pixel_reg;
    logic                 run_last_reg;
    logic                 row_end_reg;
    logic                 error_reg;

    logic [ROW_LEN_W-1:0] len_eff;
    logic [ROW_LEN_W:0]   col_inc;
    logic                 wrap;
    logic [ROW_LEN_W:0]   run_sum;
    logic                 fits;
    logic                 odd_one;
    logic [COUNT_W-1:0]   run_len;
    logic                 advance;

    // a row length of zero behaves as one
    assign len_eff = (row_length_reg == '0) ? {{(ROW_LEN_W-1){1'b0}}, 1'b1} : row_length_reg;
    assign col_inc = {1'b0, column_reg} + {{ROW_LEN_W{1'b0}}, 1'b1};
    assign wrap    = (col_inc >= {1'b0, len_eff});

    // run end position against the row end
    assign run_sum = {1'b0, column_reg} + {{(ROW_LEN_W+1-COUNT_W){1'b0}}, run_count_reg};
    assign fits    = (run_sum <= {1'b0, len_eff});
    assign odd_one = (run_sum == ({1'b0, len_eff} + {{ROW_LEN_W{1'b0}}, 1'b1})) && len_eff[0];
    assign run_len = fits ? run_count_reg : (run_count_reg - {{(COUNT_W-1){1'b0}}, 1'b1});

    assign advance = cmd.load_lit || cmd.emit;

    assign stat.is_code     = ((code_byte & CODE_MASK) == CODE_MASK);
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.run_empty   = (run_count_reg == '0);
    assign stat.run_err     = !fits && !odd_one;
    assign stat.run_last_px = (left_reg == {{(COUNT_W-1){1'b0}}, 1'b1});

    always_comb
    begin
        column_next = column_reg;
        if (cfg_valid)
        begin
            column_next = '0;
        end
        else if (advance)
        begin
            column_next = wrap ? '0 : col_inc[ROW_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LEN_RESET;
            column_reg     <= '0;
            run_count_reg  <= '0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            if (cfg_valid)
            begin
                row_length_reg <= row_length;
            end
            if (cmd.load_count)
            begin
                run_count_reg <= COUNT_W'(code_byte & COUNT_MASK);
            end
            if (cmd.start_run)
            begin
                left_reg <= run_len;
            end
            else if (cmd.emit)
            begin
                left_reg <= left_reg - {{(COUNT_W-1){1'b0}}, 1'b1};
            end
            if (advance || cmd.load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_run)
        begin
            value_reg <= code_byte;
        end
        if (cmd.load_lit)
        begin
            pixel_reg    <= code_byte;
            run_last_reg <= 1'b1;
            row_end_reg  <= wrap;
            error_reg    <= 1'b0;
        end
        else if (cmd.emit)
        begin
            pixel_reg    <= value_reg;
            run_last_reg <= stat.run_last_px;
            row_end_reg  <= wrap;
            error_reg    <= 1'b0;
        end
        else if (cmd.load_err)
        begin
            pixel_reg    <= '0;
            run_last_reg <= 1'b1;
            row_end_reg  <= 1'b0;
            error_reg    <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel         = pixel_reg;
    assign run_last      = run_last_reg;
    assign row_end       = row_end_reg;
    assign overrun_error = error_reg;

endmodule

/* src/pcx_rle_row_decoder.sv */
// Run-length decoder for pcx-style rows: one compressed byte per item in, one pixel per
// item out. Literals stream at one per cycle through the output register while the
// receiver accepts them. A run code byte yields nothing; its value byte is then followed
// by one output item per emitted pixel (count, or count less one for the odd-row
// trim), during which input is held off by the controller. A zero count consumes its
// value byte with no output. A run that overruns the row end (other than the one-pixel
// trim on odd row lengths) gives a single error item, after which all input is drained
// and dropped until reset. Writing row_length restarts the current row.
module pcx_rle_row_decoder
    import pcx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    code_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    pixel,
    output logic                 run_last,
    output logic                 row_end,
    output logic                 overrun_error,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ROW_LEN_W-1:0] row_length
);

    cmd_t   cmd;
    stat_t  stat;
    state_t state;
    logic   cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    pcx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    pcx_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_byte     (code_byte),
        .cfg_valid     (cfg_write),
        .row_length    (row_length),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .pixel         (pixel),
        .run_last      (run_last),
        .row_end       (row_end),
        .overrun_error (overrun_error)
    );

`ifndef SYNTHESIS
    // a pixel that is not the last of its item means the run is still going
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> state == S_RUN)
        else $error("non-final run pixel outside run state");

    // once halted, no new item appears at the output
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state == S_HALT && !out_valid |=> !out_valid)
        else $error("item produced after overrun halt");

    // the error item carries a zero pixel and closes its input item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overrun_error |-> pixel == '0 && run_last && !row_end && state == S_HALT)
        else $error("malformed overrun error item");
`endif

endmodule

/* dv/tb_top.sv */
// self-checking testbench of the pcx run-length row decoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcx_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_COUNT     = 63;

    typedef struct packed {
        logic [BYTE_W-1:0] px;
        logic              last;
        logic              rend;
        logic              err;
    } pixel_rec_t;

    class pixel_scoreboard;
        pixel_rec_t             pixel_q[$];
        logic [ROW_LEN_W-1:0]   row_len;
        logic [COUNT_W-1:0]     run_cnt;
        bit                     want_value;
        int unsigned            column;
        bit                     halted;
        int                     errors;
        int                     n_pixels;
        int                     n_rows;
        int                     n_trimmed;
        int                     n_overruns;

        function new();
            row_len    = ROW_LEN_RESET;
            run_cnt    = '0;
            want_value = 0;
            column     = 0;
            halted     = 0;
            errors     = 0;
            n_pixels   = 0;
            n_rows     = 0;
            n_trimmed  = 0;
            n_overruns = 0;
        endfunction

        function void set_row_length(logic [ROW_LEN_W-1:0] len);
            row_len = len;
            column  = 0;
        endfunction

        function int unsigned eff_len();
            return (row_len == '0) ? 1 : int'(row_len);
        endfunction

        function int unsigned room();
            return (column < eff_len()) ? eff_len() - column : 0;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        // place one pixel and report whether it closes the row
        function logic step_column();
            column = (column + 1) & 32'h7FFF;
            if (column >= eff_len())
            begin
                column = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_code_byte(logic [BYTE_W-1:0] b);
            int unsigned cnt;
            int unsigned n;
            logic        rend;
            if (halted)
                return;
            if (!want_value)
            begin
                if ((b & CODE_MASK) != CODE_MASK)
                begin
                    rend = step_column();
                    pixel_q.push_back('{b, 1'b1, rend, 1'b0});
                end
                else
                begin
                    run_cnt    = COUNT_W'(b & COUNT_MASK);
                    want_value = 1;
                end
                return;
            end
            want_value = 0;
            cnt = run_cnt;
            if (cnt == 0)
                return;
            if (cnt <= room())
                n = cnt;
            else if (cnt == room() + 1 && eff_len() % 2 == 1)
            begin
                // odd row: a one-pixel overshoot is trimmed
                n = cnt - 1;
                n_trimmed++;
            end
            else
            begin
                halted = 1;
                pixel_q.push_back('{'0, 1'b1, 1'b0, 1'b1});
                return;
            end
            for (int i = 0; i < n; i++)
            begin
                rend = step_column();
                pixel_q.push_back('{b, (i + 1 == n), rend, 1'b0});
            end
        endfunction

        function void check_pixel(logic [BYTE_W-1:0] px, logic last, logic rend,
                                  logic err);
            pixel_rec_t exp_rec;
            if (pixel_q.size() == 0)
            begin
                $error("unexpected item: pixel %0h run_last %0b row_end %0b overrun %0b",
                       px, last, rend, err);
                errors++;
                return;
            end
            exp_rec = pixel_q.pop_front();
            if (px !== exp_rec.px)
            begin
                $error("pixel: expected %0h, got %0h", exp_rec.px, px);
                errors++;
            end
            if (last !== exp_rec.last)
            begin
                $error("run_last: expected %0b, got %0b", exp_rec.last, last);
                errors++;
            end
            if (rend !== exp_rec.rend)
            begin
                $error("row_end: expected %0b, got %0b", exp_rec.rend, rend);
                errors++;
            end
            if (err !== exp_rec.err)
            begin
                $error("overrun_error: expected %0b, got %0b", exp_rec.err, err);
                errors++;
            end
            if (exp_rec.err)
                n_overruns++;
            else
                n_pixels++;
            if (exp_rec.rend)
                n_rows++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    code_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    pixel;
    logic                 run_last;
    logic                 row_end;
    logic                 overrun_error;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ROW_LEN_W-1:0] row_length;

    pixel_scoreboard sb = new();
    bit              idle_en;
    int unsigned     stall;

    pcx_rle_row_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_byte     (code_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel         (pixel),
        .run_last      (run_last),
        .row_end       (row_end),
        .overrun_error (overrun_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .row_length    (row_length)
    );

    always #10 clk = ~clk;

    // receiver back-pressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall     <= 0;
        end
        else if (stall != 0)
        begin
            stall     <= stall - 1;
            out_ready <= (stall == 1);
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall     <= $urandom_range(1, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && out_ready)
            sb.check_pixel(pixel, run_last, row_end, overrun_error);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= b;
        do @(posedge clk); while (!in_ready);
        sb.take_code_byte(b);
    endtask

    task automatic write_len(input logic [ROW_LEN_W-1:0] len);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // a code byte or an empty run leaves nothing to wait on, so settle first
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid  <= 1'b1;
        row_length <= len;
        do @(posedge clk); while (!cfg_ready);
        sb.set_row_length(len);
        cfg_valid <= 1'b0;
    endtask

    // well-formed stream: runs never overrun the current row
    function automatic logic [BYTE_W-1:0] next_byte();
        int unsigned lim;
        int unsigned cnt;
        if (sb.want_value)
            return BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 55)
            return BYTE_W'($urandom_range(0, 191));
        lim = sb.room() + sb.eff_len() % 2;
        if (lim > MAX_COUNT)
            lim = MAX_COUNT;
        cnt = $urandom_range(0, lim);
        if (sb.eff_len() % 2 == 1 && sb.room() < MAX_COUNT && $urandom_range(0, 3) == 0)
            cnt = sb.room() + 1;
        return CODE_MASK | BYTE_W'(cnt);
    endfunction

    initial
    begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        int unsigned          cnt;
        logic [ROW_LEN_W-1:0] len;
        idle_en    = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        code_byte  <= '0;
        cfg_valid  <= 1'b0;
        row_length <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // literal extremes at the reset row length
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h7F);
        send_byte(8'h80);
        // empty run, longest run, single run
        send_byte(CODE_MASK);
        send_byte(8'h55);
        send_byte(CODE_MASK | 8'd63);
        send_byte(8'hFF);
        send_byte(CODE_MASK | 8'd1);
        send_byte(8'h00);
        // pending run code survives a row length write
        send_byte(CODE_MASK | 8'd5);
        write_len(15'd7);
        send_byte(8'hAA);
        // odd row, overshoot by one is trimmed
        send_byte(CODE_MASK | 8'd3);
        send_byte(8'h11);
        write_len(15'd1);
        send_byte(8'h40);
        send_byte(CODE_MASK | 8'd2);
        send_byte(8'h22);
        // zero row length acts as one
        write_len(15'd0);
        send_byte(8'h01);
        send_byte(CODE_MASK | 8'd1);
        send_byte(8'h33);
        write_len(15'h7FFF);
        send_byte(8'hC0 - 8'd1);
        send_byte(CODE_MASK | 8'd63);
        send_byte(8'h5A);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
                len = 15'h7FFF;
            else if (ph == 5)
                len = '0;
            else if (ph == 6)
                len = 15'd2;
            else
                len = ROW_LEN_W'($urandom_range(1, 40));
            write_len(len);
            idle_en = (ph < 7) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 42; k++)
                send_byte(next_byte());
            if (sb.want_value)
                send_byte(next_byte());
        end

        // overrun on an even row, then bytes that the halted block drops
        idle_en = 0;
        write_len(ROW_LEN_W'(2 * $urandom_range(1, 20)));
        repeat ($urandom_range(0, 1)) send_byte(BYTE_W'($urandom_range(0, 191)));
        cnt = $urandom_range(sb.room() + 1, MAX_COUNT);
        send_byte(CODE_MASK | BYTE_W'(cnt));
        send_byte(BYTE_W'($urandom_range(0, 255)));
        repeat (4) send_byte(BYTE_W'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d pixels checked, %0d rows closed, %0d trimmed runs",
                 sb.n_pixels, sb.n_rows, sb.n_trimmed);
        $display("summary: %0d overrun item, row lengths 0, 1, 2, odd, even and 32767",
                 sb.n_overruns);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* files.f */
src/pcx_pkg.sv
src/pcx_ctrl.sv
src/pcx_dpath.sv
src/pcx_rle_row_decoder.sv
dv/tb_top.sv
